[rtl/core/lagb_pkg.sv]
// ----------------------------------------------------------------------------
// lagb_pkg
// Shared constants, register codes and types of the lidar angle gate and
// nearest-range binner.
// ----------------------------------------------------------------------------
package lagb_pkg;

  localparam int BIN_TOTAL    = 450;
  localparam int WINDOW_SLOTS = 3;
  localparam int TURN         = 36000;
  localparam int HALF_TURN    = 18000;

  localparam int BIN_W  = $clog2(BIN_TOTAL);
  localparam int ANG_W  = 18;
  localparam int RNG_W  = 16;
  localparam int CONF_W = 8;
  localparam int IDX_W  = 9;
  localparam int ST_W   = 2;

  // Wrapped angle and rounding numerator widths.
  localparam int WRAP_W = ANG_W + 1;
  localparam int NUMS_W = 28;
  localparam int NUM_W  = 26;

  // Division by one turn is a multiply by a rounded-up reciprocal.
  localparam int      RECIP_SH = 42;
  localparam int      RECIP_W  = 27;
  localparam longint  RECIP    = ((64'd1 << RECIP_SH) + TURN - 1) / TURN;
  localparam int      PROD_W   = NUM_W + RECIP_W;
  localparam int      Q_W      = PROD_W - RECIP_SH;

  // Bin status codes.
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_VALID   = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN0_LO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN0_HI   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN1_LO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN1_HI   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN2_LO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIN2_HI   = 3'd6;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [RNG_W-1:0]  rng;
    logic [CONF_W-1:0] conf;
  } lagb_entry_t;

  localparam int ENTRY_W = $bits(lagb_entry_t);

  typedef struct packed {
    logic [1:0]                          count;
    logic [WINDOW_SLOTS-1:0][ANG_W-1:0]  lo;
    logic [WINDOW_SLOTS-1:0][ANG_W-1:0]  hi;
  } lagb_win_t;

  // One request to the bin store.
  typedef struct packed {
    logic              vld;
    logic              rd;
    logic              hit;
    logic [BIN_W-1:0]  bin;
    logic [IDX_W-1:0]  ridx;
    logic [RNG_W-1:0]  rng;
    logic [CONF_W-1:0] conf;
  } lagb_req_t;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  index;
    lagb_entry_t       entry;
  } lagb_res_t;

endpackage

[rtl/core/lidar_angle_gate_and_binner_core.sv]
// ----------------------------------------------------------------------------
// lidar_angle_gate_and_binner_core
// Lidar beam window gate and 450-bin nearest-range accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions carry either a beam (in_tuser = 0) or a request to
//   read and clear one bin (in_tuser = 1). A beam produces no output; a read
//   produces exactly one output transaction with the bin's status, range and
//   confidence, after which the bin is empty again.
//   The block takes one input transaction per cycle while in_tready is high.
//   A read's result passes through the front pipeline, the store stage and
//   the output register. Bins are held in one memory, read a stage ahead and
//   written back as the item leaves; a write bypass lets back-to-back beams
//   hit the same bin. After reset all 450 bins are cleared, one per cycle;
//   in_tready stays low during that pass. Configuration writes are taken at
//   any time, but are meant to change only while the block is idle.
//   When the receiver holds out_tready low with a result waiting, the whole
//   pipeline holds and in_tready falls until the result is taken.
// ----------------------------------------------------------------------------
module lidar_angle_gate_and_binner_core
  import lagb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [17:0] beam_angle, [33:18] beam_range_mm, [41:34] beam_confidence,
  // [50:42] read_index, [55:51] zero
  input  logic [55:0]          in_tdata,
  // [0] kind
  input  logic                 in_tuser,

  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [8:0] bin_index, [10:9] bin_status, [26:11] bin_range_mm,
  // [34:27] bin_confidence, [39:35] zero
  output logic [39:0]          out_tdata,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ANG_W-1:0]     cfg_data
);

  lagb_win_t  win_r;
  lagb_req_t  req;
  lagb_res_t  res;
  logic       busy;
  logic       adv;
  logic       acc;

  logic        out_vld_r;
  logic [39:0] out_data_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv && !busy;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.count <= '0;
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        win_r.lo[i] <= '0;
        win_r.hi[i] <= ANG_W'(TURN);
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIN_COUNT: win_r.count <= cfg_data[1:0];
        REG_WIN0_LO:   win_r.lo[0] <= cfg_data;
        REG_WIN0_HI:   win_r.hi[0] <= cfg_data;
        REG_WIN1_LO:   win_r.lo[1] <= cfg_data;
        REG_WIN1_HI:   win_r.hi[1] <= cfg_data;
        REG_WIN2_LO:   win_r.lo[2] <= cfg_data;
        REG_WIN2_HI:   win_r.hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  lagb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .acc   (acc),
    .kind  (in_tuser),
    .angle (in_tdata[17:0]),
    .rng   (in_tdata[33:18]),
    .conf  (in_tdata[41:34]),
    .ridx  (in_tdata[50:42]),
    .win   (win_r),
    .req   (req)
  );

  lagb_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (req),
    .busy  (busy),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {5'b0, res.entry.conf, res.entry.rng, res.entry.status, res.index};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/core/lagb_front.sv]
// ----------------------------------------------------------------------------
// lagb_front
// Input pipeline: window gate, single wrap of the angle and rounding of the
// angle to its bin over three register stages.
// ----------------------------------------------------------------------------
module lagb_front
  import lagb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              acc,
  input  logic              kind,
  input  logic [ANG_W-1:0]  angle,
  input  logic [RNG_W-1:0]  rng,
  input  logic [CONF_W-1:0] conf,
  input  logic [IDX_W-1:0]  ridx,
  input  lagb_win_t         win,
  output lagb_req_t         req
);

  // Stage 1: accepted item.
  logic              s1_vld_r;
  logic              s1_kind_r;
  logic [ANG_W-1:0]  s1_ang_r;
  logic [RNG_W-1:0]  s1_rng_r;
  logic [CONF_W-1:0] s1_conf_r;
  logic [IDX_W-1:0]  s1_ridx_r;

  // Stage 2: gate result and rounding numerator.
  logic              s2_vld_r;
  logic              s2_kind_r;
  logic              s2_keep_r;
  logic              s2_neg_r;
  logic [NUM_W-1:0]  s2_num_r;
  logic [RNG_W-1:0]  s2_rng_r;
  logic [CONF_W-1:0] s2_conf_r;
  logic [IDX_W-1:0]  s2_ridx_r;

  // Stage 3: reciprocal product.
  logic              s3_vld_r;
  logic              s3_kind_r;
  logic              s3_keep_r;
  logic              s3_neg_r;
  logic [PROD_W-1:0] s3_prod_r;
  logic [RNG_W-1:0]  s3_rng_r;
  logic [CONF_W-1:0] s3_conf_r;
  logic [IDX_W-1:0]  s3_ridx_r;

  logic                     keep_nxt;
  logic signed [WRAP_W-1:0] wrap;
  logic signed [NUMS_W-1:0] num_s;
  logic [PROD_W-1:0]        prod_nxt;
  logic [Q_W-1:0]           quot;
  logic [BIN_W-1:0]         beam_bin;

  always_comb begin
    logic signed [ANG_W-1:0] ang;
    ang = $signed(s1_ang_r);
    keep_nxt = (win.count == 2'd0);
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      if ((2'(i) < win.count) && (ang >= $signed(win.lo[i]))
          && (ang <= $signed(win.hi[i]))) begin
        keep_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    wrap = WRAP_W'($signed(s1_ang_r));
    if (wrap < 0) begin
      wrap = wrap + WRAP_W'(TURN);
    end
    if (wrap >= WRAP_W'(TURN)) begin
      wrap = wrap - WRAP_W'(TURN);
    end
    num_s = NUMS_W'(wrap) * NUMS_W'(BIN_TOTAL) + NUMS_W'(HALF_TURN);
  end

  assign prod_nxt = PROD_W'(s2_num_r) * PROD_W'(RECIP);

  always_comb begin
    quot = s3_prod_r[PROD_W-1:RECIP_SH];
    if (s3_neg_r) begin
      beam_bin = '0;
    end else if (quot > Q_W'(BIN_TOTAL - 1)) begin
      beam_bin = BIN_W'(BIN_TOTAL - 1);
    end else begin
      beam_bin = quot[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= acc;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r <= kind;
      s1_ang_r  <= angle;
      s1_rng_r  <= rng;
      s1_conf_r <= conf;
      s1_ridx_r <= ridx;

      s2_kind_r <= s1_kind_r;
      s2_keep_r <= keep_nxt;
      s2_neg_r  <= num_s[NUMS_W-1];
      s2_num_r  <= num_s[NUM_W-1:0];
      s2_rng_r  <= s1_rng_r;
      s2_conf_r <= s1_conf_r;
      s2_ridx_r <= s1_ridx_r;

      s3_kind_r <= s2_kind_r;
      s3_keep_r <= s2_keep_r;
      s3_neg_r  <= s2_neg_r;
      s3_prod_r <= prod_nxt;
      s3_rng_r  <= s2_rng_r;
      s3_conf_r <= s2_conf_r;
      s3_ridx_r <= s2_ridx_r;
    end
  end

  // A beam outside every enabled window leaves the pipeline here.
  always_comb begin
    req.vld  = s3_vld_r && (s3_kind_r || s3_keep_r);
    req.rd   = s3_kind_r;
    req.ridx = s3_ridx_r;
    req.rng  = s3_rng_r;
    req.conf = s3_conf_r;
    if (s3_kind_r) begin
      req.hit = (s3_ridx_r < IDX_W'(BIN_TOTAL));
      req.bin = s3_ridx_r[BIN_W-1:0];
    end else begin
      req.hit = 1'b1;
      req.bin = beam_bin;
    end
  end

  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (req.vld && req.hit) |-> (req.bin < BIN_W'(BIN_TOTAL)))
    else $error("bin address beyond the store");

endmodule

[rtl/core/lagb_store.sv]
// ----------------------------------------------------------------------------
// lagb_store
// Bin memory with read-modify-write, a one-deep write bypass and the
// clearing pass that follows reset.
// ----------------------------------------------------------------------------
module lagb_store
  import lagb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  lagb_req_t  req,
  output logic       busy,
  output lagb_res_t  res
);

  logic [ENTRY_W-1:0] mem [BIN_TOTAL];

  logic               clr_r;
  logic [BIN_W-1:0]   clr_cnt_r;

  lagb_req_t          s4_r;
  lagb_entry_t        rd_q_r;

  logic               fwd_vld_r;
  logic [BIN_W-1:0]   fwd_addr_r;
  lagb_entry_t        fwd_data_r;

  lagb_entry_t        cur;
  lagb_entry_t        wr_data;
  logic               wr_en;
  logic [BIN_W-1:0]   rd_addr;

  assign busy    = clr_r;
  assign rd_addr = req.hit ? req.bin : '0;

  // The write of the item ahead lands on the same edge as this item's read.
  assign cur = (fwd_vld_r && (fwd_addr_r == s4_r.bin)) ? fwd_data_r : rd_q_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = cur;
    if (s4_r.vld && s4_r.hit) begin
      if (s4_r.rd) begin
        wr_en   = 1'b1;
        wr_data = '0;
      end else if (s4_r.rng == '0) begin
        if (cur.status == ST_EMPTY) begin
          wr_en          = 1'b1;
          wr_data.status = ST_INVALID;
          wr_data.rng    = '0;
          wr_data.conf   = s4_r.conf;
        end
      end else if ((cur.status != ST_VALID) || (s4_r.rng < cur.rng)) begin
        wr_en          = 1'b1;
        wr_data.status = ST_VALID;
        wr_data.rng    = s4_r.rng;
        wr_data.conf   = s4_r.conf;
      end
    end
  end

  always_comb begin
    res.vld   = s4_r.vld && s4_r.rd;
    res.index = s4_r.ridx;
    res.entry = s4_r.hit ? cur : '0;
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (adv && wr_en) begin
      mem[s4_r.bin] <= wr_data;
    end
    if (adv) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (clr_r) begin
        if (clr_cnt_r == BIN_W'(BIN_TOTAL - 1)) begin
          clr_r <= 1'b0;
        end
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (adv) begin
        fwd_vld_r <= wr_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.vld <= 1'b0;
    end else if (adv) begin
      s4_r.vld <= req.vld;
    end
    if (adv) begin
      s4_r.rd    <= req.rd;
      s4_r.hit   <= req.hit;
      s4_r.bin   <= req.bin;
      s4_r.ridx  <= req.ridx;
      s4_r.rng   <= req.rng;
      s4_r.conf  <= req.conf;
      fwd_addr_r <= s4_r.bin;
      fwd_data_r <= wr_data;
    end
  end

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !s4_r.vld)
    else $error("item reached the store during the clearing pass");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> (clr_cnt_r < BIN_W'(BIN_TOTAL)))
    else $error("clearing pass ran beyond the last bin");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && wr_en) |-> (wr_data.status != 2'd3))
    else $error("undefined status code written");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s4_r.vld && s4_r.rd && s4_r.hit) |=>
      (fwd_vld_r && (fwd_data_r == '0)))
    else $error("read transaction did not clear its bin");

endmodule
